/* design/drive_controller_event_unit_macros.svh */
// Assertion helpers for the drive controller event unit.
`ifndef DRIVE_CONTROLLER_EVENT_UNIT_MACROS_SVH
`define DRIVE_CONTROLLER_EVENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DCEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define DCEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dceu_pkg.sv */
package dceu_pkg;

    localparam int TRACK_COUNT_DEF = 4;
    localparam int MAX_RESULTS     = 5;
    localparam int CFG_AW          = 5;

    // opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_REMOTE = 3'd1;
    localparam logic [2:0] OP_FRONT  = 3'd2;
    localparam logic [2:0] OP_REAR   = 3'd3;
    localparam logic [2:0] OP_TOUCH  = 3'd4;
    localparam logic [2:0] OP_LIGHT  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_TOUCH_THR  = 3'd0;
    localparam logic [2:0] REG_RAMP_STEP  = 3'd1;
    localparam logic [2:0] REG_SERVO_IDLE = 3'd2;
    localparam logic [2:0] REG_SERVO_FWD  = 3'd3;
    localparam logic [2:0] REG_SERVO_REV  = 3'd4;
    localparam logic [2:0] REG_LIGHT_ON   = 3'd5;
    localparam logic [2:0] REG_LIGHT_OFF  = 3'd6;
    localparam logic [2:0] REG_OVERHEAT   = 3'd7;

    // remote keys
    localparam logic [31:0] KEY_ENGINE = 32'hE916FF00;
    localparam logic [31:0] KEY_PREV   = 32'hF30CFF00;
    localparam logic [31:0] KEY_NEXT   = 32'hE718FF00;
    localparam logic [31:0] KEY_PAUSE  = 32'hA15EFF00;
    localparam logic [31:0] KEY_OK     = 32'hBF40FF00;
    localparam logic [31:0] KEY_UP     = 32'hB946FF00;
    localparam logic [31:0] KEY_DOWN   = 32'hEA15FF00;
    localparam logic [31:0] KEY_LEFT   = 32'hBB44FF00;
    localparam logic [31:0] KEY_RIGHT  = 32'hBC43FF00;

    // bus command bytes
    localparam logic [7:0] CMD_LIGHT_ON   = 8'd10;
    localparam logic [7:0] CMD_LIGHT_OFF  = 8'd11;
    localparam logic [7:0] CMD_LEFT       = 8'd20;
    localparam logic [7:0] CMD_LEFT_OFF   = 8'd21;
    localparam logic [7:0] CMD_RIGHT      = 8'd30;
    localparam logic [7:0] CMD_RIGHT_OFF  = 8'd31;
    localparam logic [7:0] CMD_START      = 8'd40;
    localparam logic [7:0] CMD_GO         = 8'd41;
    localparam logic [7:0] CMD_TRACK_BASE = 8'd60;
    localparam logic [7:0] CMD_PAUSE      = 8'd66;
    localparam logic [7:0] CMD_EMERGENCY  = 8'd99;

    // result kinds
    localparam logic KIND_BUS   = 1'b0;
    localparam logic KIND_SERVO = 1'b1;

    // direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [7:0]  NEAR_LIMIT  = 8'd15;
    localparam logic [6:0]  SPEED_MAX   = 7'd100;
    localparam logic [11:0] ADC_FULL    = 12'd4095;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [11:0] touch_thr;
        logic [6:0]  ramp_step;
        logic [7:0]  servo_idle;
        logic [7:0]  servo_fwd;
        logic [7:0]  servo_rev;
        logic [6:0]  light_on;
        logic [6:0]  light_off;
        logic [7:0]  overheat;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        touch_thr:  12'd1500,
        ramp_step:  7'd2,
        servo_idle: 8'd90,
        servo_fwd:  8'd180,
        servo_rev:  8'd0,
        light_on:   7'd75,
        light_off:  7'd55,
        overheat:   8'd24
    };

endpackage

/* design/dceu_cfg.sv */
module dceu_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dceu_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output dceu_pkg::t_cfg              o_cfg
);

    dceu_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dceu_pkg::CFG_AW-1:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_comb begin
        unique case (reg_idx)
            dceu_pkg::REG_TOUCH_THR:  prdata = 32'(r_cfg.touch_thr);
            dceu_pkg::REG_RAMP_STEP:  prdata = 32'(r_cfg.ramp_step);
            dceu_pkg::REG_SERVO_IDLE: prdata = 32'(r_cfg.servo_idle);
            dceu_pkg::REG_SERVO_FWD:  prdata = 32'(r_cfg.servo_fwd);
            dceu_pkg::REG_SERVO_REV:  prdata = 32'(r_cfg.servo_rev);
            dceu_pkg::REG_LIGHT_ON:   prdata = 32'(r_cfg.light_on);
            dceu_pkg::REG_LIGHT_OFF:  prdata = 32'(r_cfg.light_off);
            dceu_pkg::REG_OVERHEAT:   prdata = 32'(r_cfg.overheat);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dceu_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                dceu_pkg::REG_TOUCH_THR:  r_cfg.touch_thr  <= pwdata[11:0];
                dceu_pkg::REG_RAMP_STEP:  r_cfg.ramp_step  <= pwdata[6:0];
                dceu_pkg::REG_SERVO_IDLE: r_cfg.servo_idle <= pwdata[7:0];
                dceu_pkg::REG_SERVO_FWD:  r_cfg.servo_fwd  <= pwdata[7:0];
                dceu_pkg::REG_SERVO_REV:  r_cfg.servo_rev  <= pwdata[7:0];
                dceu_pkg::REG_LIGHT_ON:   r_cfg.light_on   <= pwdata[6:0];
                dceu_pkg::REG_LIGHT_OFF:  r_cfg.light_off  <= pwdata[6:0];
                dceu_pkg::REG_OVERHEAT:   r_cfg.overheat   <= pwdata[7:0];
            endcase
        end
    end

endmodule

/* design/drive_controller_event_unit.sv */
// Drive controller event unit.
// Input channel (i_in_valid / o_in_ready) carries one event request: opcode plus
// remote code, distance, temperature and analog sample. Output channel
// (o_out_valid / i_out_ready) returns zero to five results per event, one per
// cycle while ready, each with kind, value and a last flag on the final one of the event.
// Configuration registers sit behind the APB port, one per word address.
// The first result is registered: a request passes the input register and
// then the result buffer; a running ramp tick also passes a servo scaling
// step (reciprocal multiply). Throughput: one event per cycle while the
// receiver is ready and each event gives at most one result and is no running
// ramp tick. An event with several results holds the result buffer until its
// last result is taken; one further event waits in the input register meanwhile.
// Reset (synchronous, active low) clears all flags and speeds, sets both
// distances to 255 and loads the register reset values; no results pending.
// A stalled receiver holds the current result; the input register then fills
// and o_in_ready drops until the result buffer frees up.
`include "drive_controller_event_unit_macros.svh"

module drive_controller_event_unit #(
    parameter int TRACK_COUNT = dceu_pkg::TRACK_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_opcode,
    input  logic [31:0]                 i_remote_code,
    input  logic [7:0]                  i_distance,
    input  logic [7:0]                  i_temperature,
    input  logic [11:0]                 i_analog_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_kind,
    output logic [7:0]                  o_value,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dceu_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int TW = $clog2(TRACK_COUNT);
    localparam int NR = dceu_pkg::MAX_RESULTS;

    dceu_pkg::t_cfg cfg;

    dceu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic        r_in_vld;
    logic [2:0]  r_op;
    logic [31:0] r_code;
    logic [7:0]  r_dist;
    logic [7:0]  r_temp_in;
    logic [11:0] r_sample;

    // state
    logic          r_engine, n_engine;
    logic          r_fault, n_fault;
    logic [6:0]    r_speed, n_speed;
    logic [6:0]    r_target, n_target;
    logic [1:0]    r_dir, n_dir;
    logic [TW-1:0] r_track, n_track;
    logic          r_touch, n_touch;
    logic          r_lights, n_lights;
    logic [7:0]    r_front, n_front;
    logic [7:0]    r_rear, n_rear;
    logic [7:0]    r_temp, n_temp;

    // result buffer
    logic               r_kind [NR];
    logic [7:0]         r_val  [NR];
    logic [2:0]         r_cnt;
    logic               r_pend;
    logic signed [16:0] r_prod;

    logic         res_kind [NR];
    logic [7:0]   res_val  [NR];
    logic [2:0]   res_cnt;
    logic         res_pend;

    logic         running, key_eng, do_toggle, tog_eng, trip_chk;
    logic         front_hit, rear_hit, hot;
    logic         batch_free, adv, out_acc;

    // tick speed and servo product
    logic [7:0]         spd_up;
    logic [6:0]         spd_tick;
    logic signed [8:0]  tick_diff;
    logic signed [16:0] tick_prod;

    // light compare
    logic [19:0] s100, on_lim, off_lim;

    // servo scaling
    logic [14:0] pend_mag;
    logic [27:0] pend_scaled;
    logic [7:0]  pend_q, pend_val;

    assign running = r_engine & ~r_fault;
    assign key_eng = r_engine | r_fault;

    assign spd_up = 8'(r_speed) + 8'(cfg.ramp_step);

    always_comb begin
        if (r_speed < r_target) begin
            spd_tick = (spd_up > 8'(dceu_pkg::SPEED_MAX)) ? dceu_pkg::SPEED_MAX : spd_up[6:0];
        end else if (r_speed > r_target) begin
            spd_tick = (r_speed > cfg.ramp_step) ? r_speed - cfg.ramp_step : 7'd0;
        end else begin
            spd_tick = r_speed;
        end
        if (r_dir == dceu_pkg::DIR_FWD) begin
            tick_diff = $signed({1'b0, cfg.servo_fwd}) - $signed({1'b0, cfg.servo_idle});
        end else if (r_dir == dceu_pkg::DIR_REV) begin
            tick_diff = $signed({1'b0, cfg.servo_rev}) - $signed({1'b0, cfg.servo_idle});
        end else begin
            tick_diff = '0;
        end
    end

    assign tick_prod = $signed({1'b0, spd_tick}) * tick_diff;

    assign s100    = 20'(r_sample) * 20'd100;
    assign on_lim  = (20'(cfg.light_on) + 20'd1) * 20'(dceu_pkg::ADC_FULL);
    assign off_lim = 20'(cfg.light_off) * 20'(dceu_pkg::ADC_FULL);

    always_comb begin
        n_engine  = r_engine;
        n_fault   = r_fault;
        n_speed   = r_speed;
        n_target  = r_target;
        n_dir     = r_dir;
        n_track   = r_track;
        n_touch   = r_touch;
        n_lights  = r_lights;
        n_front   = r_front;
        n_rear    = r_rear;
        n_temp    = r_temp;
        res_cnt   = '0;
        res_pend  = 1'b0;
        for (int i = 0; i < NR; i++) begin
            res_kind[i] = dceu_pkg::KIND_BUS;
            res_val[i]  = '0;
        end
        do_toggle = 1'b0;
        tog_eng   = r_engine;
        trip_chk  = 1'b0;

        unique case (r_op)
            dceu_pkg::OP_TICK: begin
                if (running) begin
                    n_speed     = spd_tick;
                    res_kind[0] = dceu_pkg::KIND_SERVO;
                    res_cnt     = 3'd1;
                    res_pend    = 1'b1;
                    if (spd_tick == '0 && r_target == '0) begin
                        n_dir = dceu_pkg::DIR_STOP;
                    end
                end
            end
            dceu_pkg::OP_REMOTE: begin
                if (r_code != '0) begin
                    if (r_fault) begin
                        n_fault  = 1'b0;
                        n_engine = 1'b1;
                    end
                    if (r_code == dceu_pkg::KEY_ENGINE) begin
                        do_toggle = 1'b1;
                        tog_eng   = key_eng;
                    end else if (key_eng) begin
                        case (r_code)
                            dceu_pkg::KEY_PREV: begin
                                n_track = (r_track == '0) ? TW'(TRACK_COUNT - 1)
                                                          : r_track - 1'b1;
                                res_val[0] = dceu_pkg::CMD_TRACK_BASE + 8'(n_track);
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_NEXT: begin
                                n_track = (r_track == TW'(TRACK_COUNT - 1)) ? '0
                                                                            : r_track + 1'b1;
                                res_val[0] = dceu_pkg::CMD_TRACK_BASE + 8'(n_track);
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_PAUSE: begin
                                res_val[0] = dceu_pkg::CMD_PAUSE;
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_UP: begin
                                if (r_dir != dceu_pkg::DIR_FWD) begin
                                    n_speed = '0;
                                    n_dir   = dceu_pkg::DIR_FWD;
                                end
                                n_target   = dceu_pkg::SPEED_MAX;
                                res_val[0] = dceu_pkg::CMD_GO;
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_DOWN: begin
                                if (r_dir != dceu_pkg::DIR_REV) begin
                                    n_speed = '0;
                                    n_dir   = dceu_pkg::DIR_REV;
                                end
                                n_target   = dceu_pkg::SPEED_MAX;
                                res_val[0] = dceu_pkg::CMD_GO;
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_OK: begin
                                n_target   = '0;
                                res_val[0] = dceu_pkg::CMD_START;
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_LEFT: begin
                                res_val[0] = dceu_pkg::CMD_LEFT;
                                res_cnt    = 3'd1;
                            end
                            dceu_pkg::KEY_RIGHT: begin
                                res_val[0] = dceu_pkg::CMD_RIGHT;
                                res_cnt    = 3'd1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            dceu_pkg::OP_FRONT: begin
                n_front  = r_dist;
                n_temp   = r_temp_in;
                trip_chk = running;
            end
            dceu_pkg::OP_REAR: begin
                n_rear   = r_dist;
                trip_chk = running;
            end
            dceu_pkg::OP_TOUCH: begin
                if (r_sample > cfg.touch_thr) begin
                    if (!r_touch) begin
                        n_touch   = 1'b1;
                        do_toggle = 1'b1;
                        tog_eng   = r_engine;
                    end
                end else begin
                    n_touch = 1'b0;
                end
            end
            dceu_pkg::OP_LIGHT: begin
                if (running) begin
                    if (s100 >= on_lim && !r_lights) begin
                        res_val[0] = dceu_pkg::CMD_LIGHT_ON;
                        res_cnt    = 3'd1;
                        n_lights   = 1'b1;
                    end else if (s100 < off_lim && r_lights) begin
                        res_val[0] = dceu_pkg::CMD_LIGHT_OFF;
                        res_cnt    = 3'd1;
                        n_lights   = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        // obstacle / overheat trip on the stored sensor values
        front_hit = (n_dir == dceu_pkg::DIR_FWD) && (n_front < dceu_pkg::NEAR_LIMIT)
                    && (n_front != '0);
        rear_hit  = (n_dir == dceu_pkg::DIR_REV) && (n_rear < dceu_pkg::NEAR_LIMIT)
                    && (n_rear != '0);
        hot       = n_temp > cfg.overheat;
        if (trip_chk && (front_hit || rear_hit || hot)) begin
            n_fault     = 1'b1;
            n_target    = '0;
            n_speed     = '0;
            res_kind[0] = dceu_pkg::KIND_SERVO;
            res_val[0]  = cfg.servo_idle;
            res_val[1]  = dceu_pkg::CMD_EMERGENCY;
            res_cnt     = 3'd2;
        end

        if (do_toggle) begin
            if (tog_eng) begin
                n_engine    = 1'b0;
                n_speed     = '0;
                n_target    = '0;
                n_dir       = dceu_pkg::DIR_STOP;
                res_kind[0] = dceu_pkg::KIND_SERVO;
                res_val[0]  = cfg.servo_idle;
                res_val[1]  = dceu_pkg::CMD_GO;
                res_val[2]  = dceu_pkg::CMD_LIGHT_OFF;
                res_val[3]  = dceu_pkg::CMD_LEFT_OFF;
                res_val[4]  = dceu_pkg::CMD_RIGHT_OFF;
                res_cnt     = 3'd5;
            end else begin
                n_engine   = 1'b1;
                n_fault    = 1'b0;
                res_val[0] = dceu_pkg::CMD_START;
                res_cnt    = 3'd1;
            end
        end
    end

    // servo = stop + trunc(speed * diff / 100), reciprocal multiply
    assign pend_mag    = r_prod[16] ? 15'(-r_prod) : 15'(r_prod);
    assign pend_scaled = 28'(pend_mag) * 28'(dceu_pkg::RECIP_100);
    assign pend_q      = pend_scaled[dceu_pkg::RECIP_SHIFT +: 8];
    assign pend_val    = r_prod[16] ? cfg.servo_idle - pend_q : cfg.servo_idle + pend_q;

    assign o_out_valid = (r_cnt != '0) && !r_pend;
    assign o_kind      = r_kind[0];
    assign o_value     = r_val[0];
    assign o_last      = (r_cnt == 3'd1);
    assign out_acc     = o_out_valid && i_out_ready;
    assign batch_free  = (r_cnt == '0) || (o_last && out_acc);
    assign adv         = r_in_vld && batch_free;
    assign o_in_ready  = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= i_opcode;
            r_code    <= i_remote_code;
            r_dist    <= i_distance;
            r_temp_in <= i_temperature;
            r_sample  <= i_analog_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engine <= 1'b0;
            r_fault  <= 1'b0;
            r_speed  <= '0;
            r_target <= '0;
            r_dir    <= dceu_pkg::DIR_STOP;
            r_track  <= '0;
            r_touch  <= 1'b0;
            r_lights <= 1'b0;
            r_front  <= 8'd255;
            r_rear   <= 8'd255;
            r_temp   <= '0;
        end else if (adv) begin
            r_engine <= n_engine;
            r_fault  <= n_fault;
            r_speed  <= n_speed;
            r_target <= n_target;
            r_dir    <= n_dir;
            r_track  <= n_track;
            r_touch  <= n_touch;
            r_lights <= n_lights;
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_temp   <= n_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (adv) begin
            r_cnt  <= res_cnt;
            r_pend <= res_pend;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 3'd1;
        end else if (r_pend) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind <= res_kind;
            r_val  <= res_val;
            r_prod <= tick_prod;
        end else if (out_acc) begin
            for (int i = 0; i < NR - 1; i++) begin
                r_kind[i] <= r_kind[i + 1];
                r_val[i]  <= r_val[i + 1];
            end
        end else if (r_pend) begin
            r_val[0] <= pend_val;
        end
    end

    `DCEU_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= 3'(NR), "result count out of range")
    `DCEU_ASSERT_NOW(a_pend_single, r_pend, r_cnt == 3'd1, "servo scaling with extra results")
    `DCEU_ASSERT_NOW(a_fault_stopped, r_fault, r_speed == '0 && r_target == '0,
                     "speed nonzero under fault")
    `DCEU_ASSERT_NEXT(a_pend_clears, r_pend && !adv, !r_pend, "servo scaling stuck")

endmodule

/* dv/drive_event_checker.sv */
module drive_event_checker #(
    parameter int TRACK_COUNT = dceu_pkg::TRACK_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [2:0]                  i_opcode,
    input  logic [31:0]                 i_remote_code,
    input  logic [7:0]                  i_distance,
    input  logic [7:0]                  i_temperature,
    input  logic [11:0]                 i_analog_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_kind,
    input  logic [7:0]                  i_value,
    input  logic                        i_last,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [dceu_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output logic                        o_engine_on
);
    import dceu_pkg::*;

    localparam int PERCENT = 100;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } drive_cmd_t;

    drive_cmd_t owed_cmds[$];
    drive_cmd_t event_cmds[$];
    drive_cmd_t seen, want;

    t_cfg        regs;
    logic        engine_on, fault, touch_held, lights_on;
    logic [6:0]  speed_now, speed_target;
    logic [1:0]  direction;
    int unsigned track;
    logic [7:0]  front_dist, rear_dist, last_temp;
    int          fails = 0;

    function automatic void emit(input logic kind, input logic [7:0] value);
        drive_cmd_t c;
        if (event_cmds.size() >= MAX_RESULTS) return;
        c.kind  = kind;
        c.value = value;
        c.last  = 1'b0;
        event_cmds.push_back(c);
    endfunction

    function automatic logic [7:0] servo_at(input logic [7:0] max_pos);
        int stop_pos, span, pos;
        stop_pos = int'(regs.servo_idle);
        span     = int'(max_pos) - stop_pos;
        pos      = stop_pos + (int'(speed_now) * span) / int'(SPEED_MAX);
        return pos[7:0];
    endfunction

    function automatic void toggle_engine();
        if (engine_on) begin
            engine_on = 1'b0;
            emit(KIND_SERVO, regs.servo_idle);
            speed_now    = '0;
            speed_target = '0;
            direction    = DIR_STOP;
            emit(KIND_BUS, CMD_GO);
            emit(KIND_BUS, CMD_LIGHT_OFF);
            emit(KIND_BUS, CMD_LEFT_OFF);
            emit(KIND_BUS, CMD_RIGHT_OFF);
        end else begin
            engine_on = 1'b1;
            fault     = 1'b0;
            emit(KIND_BUS, CMD_START);
        end
    endfunction

    function automatic void ramp_tick();
        int s;
        if (!engine_on || fault) return;
        s = int'(speed_now);
        if (speed_now < speed_target) s += int'(regs.ramp_step);
        else if (speed_now > speed_target) s -= int'(regs.ramp_step);
        if (s < 0) s = 0;
        if (s > int'(SPEED_MAX)) s = int'(SPEED_MAX);
        speed_now = s[6:0];
        if (direction == DIR_FWD) emit(KIND_SERVO, servo_at(regs.servo_fwd));
        else if (direction == DIR_REV) emit(KIND_SERVO, servo_at(regs.servo_rev));
        else emit(KIND_SERVO, regs.servo_idle);
        if (speed_now == '0 && speed_target == '0) direction = DIR_STOP;
    endfunction

    function automatic void remote_key(input logic [31:0] code);
        if (code == '0) return;
        if (fault) begin
            fault     = 1'b0;
            engine_on = 1'b1;
        end
        if (code == KEY_ENGINE) begin
            toggle_engine();
            return;
        end
        if (!engine_on) return;
        case (code)
            KEY_PREV: begin
                track = (track == 0 || track >= TRACK_COUNT) ? TRACK_COUNT - 1 : track - 1;
                emit(KIND_BUS, CMD_TRACK_BASE + 8'(track));
            end
            KEY_NEXT: begin
                track = (track + 1 >= TRACK_COUNT) ? 0 : track + 1;
                emit(KIND_BUS, CMD_TRACK_BASE + 8'(track));
            end
            KEY_PAUSE: emit(KIND_BUS, CMD_PAUSE);
            KEY_UP: begin
                if (direction != DIR_FWD) begin
                    speed_now = '0;
                    direction = DIR_FWD;
                end
                speed_target = SPEED_MAX;
                emit(KIND_BUS, CMD_GO);
            end
            KEY_DOWN: begin
                if (direction != DIR_REV) begin
                    speed_now = '0;
                    direction = DIR_REV;
                end
                speed_target = SPEED_MAX;
                emit(KIND_BUS, CMD_GO);
            end
            KEY_OK: begin
                speed_target = '0;
                emit(KIND_BUS, CMD_START);
            end
            KEY_LEFT:  emit(KIND_BUS, CMD_LEFT);
            KEY_RIGHT: emit(KIND_BUS, CMD_RIGHT);
            default: ;
        endcase
    endfunction

    function automatic void sensor_check();
        logic ahead, behind, hot;
        if (!engine_on || fault) return;
        ahead  = direction == DIR_FWD && front_dist < NEAR_LIMIT && front_dist != '0;
        behind = direction == DIR_REV && rear_dist < NEAR_LIMIT && rear_dist != '0;
        hot    = last_temp > regs.overheat;
        if (ahead || behind || hot) begin
            fault        = 1'b1;
            speed_target = '0;
            speed_now    = '0;
            emit(KIND_SERVO, regs.servo_idle);
            emit(KIND_BUS, CMD_EMERGENCY);
        end
    endfunction

    function automatic void light_level(input logic [11:0] sample);
        int pct;
        if (!engine_on || fault) return;
        pct = int'(sample) * PERCENT / int'(ADC_FULL);
        if (pct > int'(regs.light_on) && !lights_on) begin
            emit(KIND_BUS, CMD_LIGHT_ON);
            lights_on = 1'b1;
        end else if (pct < int'(regs.light_off) && lights_on) begin
            emit(KIND_BUS, CMD_LIGHT_OFF);
            lights_on = 1'b0;
        end
    endfunction

    function automatic void react_to_event(input logic [2:0] op, input logic [31:0] code,
                                           input logic [7:0] dist_cm, input logic [7:0] temp,
                                           input logic [11:0] sample);
        drive_cmd_t c;
        event_cmds.delete();
        case (op)
            OP_TICK:   ramp_tick();
            OP_REMOTE: remote_key(code);
            OP_FRONT: begin
                front_dist = dist_cm;
                last_temp  = temp;
                sensor_check();
            end
            OP_REAR: begin
                rear_dist = dist_cm;
                sensor_check();
            end
            OP_TOUCH: begin
                if (sample > regs.touch_thr) begin
                    if (!touch_held) begin
                        touch_held = 1'b1;
                        toggle_engine();
                    end
                end else begin
                    touch_held = 1'b0;
                end
            end
            OP_LIGHT: light_level(sample);
            default: ;
        endcase
        if (event_cmds.size() > 0) begin
            c = event_cmds.pop_back();
            c.last = 1'b1;
            event_cmds.push_back(c);
        end
        foreach (event_cmds[i]) owed_cmds.push_back(event_cmds[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs         = CFG_RESET;
            engine_on    = 1'b0;
            fault        = 1'b0;
            touch_held   = 1'b0;
            lights_on    = 1'b0;
            speed_now    = '0;
            speed_target = '0;
            direction    = DIR_STOP;
            track        = 0;
            front_dist   = '1;
            rear_dist    = '1;
            last_temp    = '0;
            owed_cmds.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_TOUCH_THR:  regs.touch_thr  = i_pwdata[11:0];
                    REG_RAMP_STEP:  regs.ramp_step  = i_pwdata[6:0];
                    REG_SERVO_IDLE: regs.servo_idle = i_pwdata[7:0];
                    REG_SERVO_FWD:  regs.servo_fwd  = i_pwdata[7:0];
                    REG_SERVO_REV:  regs.servo_rev  = i_pwdata[7:0];
                    REG_LIGHT_ON:   regs.light_on   = i_pwdata[6:0];
                    REG_LIGHT_OFF:  regs.light_off  = i_pwdata[6:0];
                    REG_OVERHEAT:   regs.overheat   = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                react_to_event(i_opcode, i_remote_code, i_distance, i_temperature,
                               i_analog_sample);
            end
            if (i_out_valid && i_out_ready) begin
                seen.kind  = i_kind;
                seen.value = i_value;
                seen.last  = i_last;
                if (owed_cmds.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d last %0d",
                           seen.kind, seen.value, seen.last);
                    fails++;
                end else begin
                    want = owed_cmds.pop_front();
                    if (seen.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, seen.kind);
                        fails++;
                    end
                    if (seen.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, seen.value);
                        fails++;
                    end
                    if (seen.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, seen.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_cmds.size();
        o_engine_on  <= engine_on;
    end

endmodule

/* dv/tb_drive_controller_event_unit.sv */
module tb_drive_controller_event_unit;
    import dceu_pkg::*;

    localparam int STOP_AFTER = 3_000_000;
    localparam logic [2:0] OP_SPARE_A = OP_LIGHT + 3'd1;
    localparam logic [2:0] OP_SPARE_B = OP_LIGHT + 3'd2;
    localparam logic [31:0] KEY_SET [12] = '{KEY_UP, KEY_UP, KEY_DOWN, KEY_OK, KEY_PREV,
                                             KEY_NEXT, KEY_PAUSE, KEY_LEFT, KEY_RIGHT,
                                             KEY_ENGINE, KEY_OK, KEY_DOWN};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [2:0]  opcode        = '0;
    logic [31:0] remote_code   = '0;
    logic [7:0]  distance      = '0;
    logic [7:0]  temperature   = '0;
    logic [11:0] analog_sample = '0;
    logic        out_ready     = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0] pwdata        = '0;

    logic        in_ready, out_valid, kind, last, pready;
    logic [7:0]  value;
    logic [31:0] prdata;
    int          fail_count, pending;
    logic        engine_hint;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold    = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    drive_controller_event_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_remote_code  (remote_code),
        .i_distance     (distance),
        .i_temperature  (temperature),
        .i_analog_sample(analog_sample),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (kind),
        .o_value        (value),
        .o_last         (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    drive_event_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_remote_code  (remote_code),
        .i_distance     (distance),
        .i_temperature  (temperature),
        .i_analog_sample(analog_sample),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_kind         (kind),
        .i_value        (value),
        .i_last         (last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_engine_on    (engine_hint)
    );

    // receiver backpressure in bursts
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            rx_hold   <= $urandom_range(1, 9) - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [31:0] code,
                                input logic [7:0] dist_cm, input logic [7:0] temp,
                                input logic [11:0] sample);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        remote_code   <= code;
        distance      <= dist_cm;
        temperature   <= temp;
        analog_sample <= sample;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold off until every owed result is out, then let a silent event finish
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_regs(input int thr, input int ramp, input int stop_pos,
                                input int fwd, input int rev, input int lamp_on,
                                input int lamp_off, input int heat);
        apb_write(REG_TOUCH_THR, thr);
        apb_write(REG_RAMP_STEP, ramp);
        apb_write(REG_SERVO_IDLE, stop_pos);
        apb_write(REG_SERVO_FWD, fwd);
        apb_write(REG_SERVO_REV, rev);
        apb_write(REG_LIGHT_ON, lamp_on);
        apb_write(REG_LIGHT_OFF, lamp_off);
        apb_write(REG_OVERHEAT, heat);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_request();
        logic [2:0]  op;
        logic [31:0] code;
        logic [7:0]  dist_cm, temp;
        logic [11:0] sample;
        int          pick, k;
        code    = $urandom;
        dist_cm = 8'($urandom);
        temp    = 8'($urandom);
        sample  = 12'($urandom);
        pick    = $urandom_range(0, 99);
        op      = OP_TICK;
        if (!engine_hint && pick < 60) begin
            op   = OP_REMOTE;
            code = KEY_ENGINE;
        end else if (pick < 30) begin
            op = OP_TICK;
        end else if (pick < 55) begin
            op = OP_REMOTE;
            k  = $urandom_range(0, 13);
            if (k < 12) code = KEY_SET[k];
            else if (k == 12) code = '0;
        end else if (pick < 73) begin
            op = (pick < 65) ? OP_FRONT : OP_REAR;
            if ($urandom_range(0, 2) == 0) dist_cm = 8'($urandom_range(1, 14));
            if ($urandom_range(0, 3) != 0) temp = 8'($urandom_range(0, 30));
        end else if (pick < 80) begin
            op = OP_TOUCH;
        end else if (pick < 98) begin
            op = OP_LIGHT;
        end else begin
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end
        send_request(op, code, dist_cm, temp, sample);
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        repeat (count) begin
            if (!allow_idle) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
                tx_idle_on = !tx_idle_on;
                rx_idle_on = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 79) == 0) settle();
            random_request();
        end
    endtask

    initial begin
        #(STOP_AFTER);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_TICK, '0, '0, '0, '0);
        send_request(OP_REMOTE, '0, '1, '1, '1);
        send_request(OP_REMOTE, KEY_UP, '0, '0, '0);
        send_request(OP_LIGHT, '0, '0, '0, '1);
        send_request(OP_REMOTE, KEY_ENGINE, '0, '0, '0);
        send_request(OP_REMOTE, KEY_PREV, '0, '0, '0);
        send_request(OP_REMOTE, KEY_NEXT, '0, '0, '0);
        send_request(OP_REMOTE, KEY_PAUSE, '0, '0, '0);
        send_request(OP_REMOTE, KEY_LEFT, '0, '0, '0);
        send_request(OP_REMOTE, KEY_RIGHT, '0, '0, '0);
        send_request(OP_REMOTE, '1, '0, '0, '0);
        send_request(OP_REMOTE, KEY_UP, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0, '0);
        send_request(OP_LIGHT, '0, '0, '0, '1);
        send_request(OP_LIGHT, '0, '0, '0, '0);
        send_request(OP_REAR, '0, 8'd5, '0, '0);
        send_request(OP_FRONT, '0, '0, '0, '0);
        send_request(OP_FRONT, '0, 8'd14, '0, '0);
        send_request(OP_TICK, '0, '0, '0, '0);
        send_request(OP_REMOTE, KEY_DOWN, '0, '0, '0);
        send_request(OP_REAR, '0, 8'd1, '0, '0);
        send_request(OP_REMOTE, KEY_OK, '0, '0, '0);
        send_request(OP_FRONT, '0, '1, '1, '0);
        send_request(OP_SPARE_A, '1, '1, '1, '1);
        send_request(OP_SPARE_B, '1, '1, '1, '1);
        send_request(OP_TOUCH, '0, '0, '0, '1);
        send_request(OP_TOUCH, '0, '0, '0, '1);
        send_request(OP_TOUCH, '0, '0, '0, 12'd1500);
        send_request(OP_TOUCH, '0, '0, '0, 12'd1501);
        send_request(OP_REMOTE, KEY_ENGINE, '0, '0, '0);

        settle();
        program_regs($urandom_range(0, 4095), $urandom_range(1, 100), $urandom_range(0, 180),
                     $urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 100),
                     $urandom_range(0, 100), $urandom_range(0, 255));
        run_random(140, 1'b1);

        settle();
        program_regs(0, 1, 0, 0, 0, 0, 0, 0);
        run_random(70, 1'b1);

        settle();
        program_regs(4095, 100, 180, 180, 180, 100, 100, 255);
        run_random(70, 1'b1);

        settle();
        program_regs(0, 100, 180, 0, 180, 0, 100, 255);
        run_random(90, 1'b1);

        settle();
        program_regs($urandom_range(0, 4095), $urandom_range(1, 100), $urandom_range(0, 180),
                     $urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 100),
                     $urandom_range(0, 100), $urandom_range(0, 255));
        run_random(100, 1'b0);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
